// ===== rtl/aes128_block_mode_engine_macros.svh =====
// assertion macros shared by the engine rtl
`ifndef AES128_BLOCK_MODE_ENGINE_MACROS_SVH
`define AES128_BLOCK_MODE_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define AESME_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define AESME_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aesme_pkg.sv =====
// types, tables and round functions for the aes-128 block mode engine
package aesme_pkg;

  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_UPPER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOWER  = 3'd5;

  // mode codes
  localparam logic [2:0] MODE_ECB = 3'd0;
  localparam logic [2:0] MODE_CBC = 3'd1;
  localparam logic [2:0] MODE_CFB = 3'd2;
  localparam logic [2:0] MODE_OFB = 3'd3;
  localparam logic [2:0] MODE_CTR = 3'd4;

  localparam int NUM_ROUNDS = 10;

  // control for one pass of the round unit
  typedef struct packed {
    logic dec;
    logic last;
  } round_ctl_t;

  localparam logic [0:255][7:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  // round constant for round r (1..10)
  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 is the most significant byte
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = inv ? INV_SBOX[byte_at(s, i)] : SBOX[byte_at(s, i)];
    end
    return r;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        r[127 - 8*(i + 4*c) -: 8] = byte_at(s, i + 4*((c + i) % 4));
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        r[127 - 8*(i + 4*((c + i) % 4)) -: 8] = byte_at(s, i + 4*c);
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c);
      a1 = byte_at(s, 4*c + 1);
      a2 = byte_at(s, 4*c + 2);
      a3 = byte_at(s, 4*c + 3);
      r[127 - 32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                             xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    end
    return r;
  endfunction

  // multiples 9, 11, 13, 14 built from doublings
  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    for (int i = 0; i < 4; i++) begin
      a[i]   = w[31 - 8*i -: 8];
      m2[i]  = xt(a[i]);
      m4[i]  = xt(m2[i]);
      m8[i]  = xt(m4[i]);
      m9[i]  = m8[i] ^ a[i];
      m11[i] = m8[i] ^ m2[i] ^ a[i];
      m13[i] = m8[i] ^ m4[i] ^ a[i];
      m14[i] = m8[i] ^ m4[i] ^ m2[i];
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r[127 - 32*c -: 32] = inv_mix_col(s[127 - 32*c -: 32]);
    end
    return r;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {SBOX[k[23:16]] ^ rcon(r), SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// ===== rtl/aes128_block_mode_engine.sv =====
// aes-128 block mode engine: ecb, cbc, cfb, ofb, ctr over one shared round unit
// result: key add on accept, then the NUM_ROUNDS rounds, then the output register
// a new block is taken only after the one in flight finishes, set by the single round unit used once per round
// a finished result waits in the output register while the next block is taken
// after reset the round keys of the zero key are expanded; a key write restarts the expansion
// reset clears configuration registers, chaining value and handshakes; input is held off meanwhile
module aes128_block_mode_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aesme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     block_upper,
  input  logic [63:0]                     block_lower,
  input  logic                            message_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [63:0]                     result_upper,
  output logic [63:0]                     result_lower
);
  import aesme_pkg::*;

  `include "aes128_block_mode_engine_macros.svh"

  logic [2:0]   mode;
  logic         direction;
  logic [127:0] key;
  logic [127:0] iv;
  logic [127:0] chain;

  logic         busy;
  logic [3:0]   step;
  logic [2:0]   mode_r;
  logic         dirn_r;
  logic         dec_r;
  logic [127:0] p_r;
  logic [127:0] c_r;
  logic [127:0] state;

  logic         kx_busy;
  logic         kx_start;
  logic [3:0]   rd_idx;
  logic [127:0] rd_key;
  round_ctl_t   ctl;
  logic [127:0] round_out;

  logic         cfg_fire;
  logic         in_fire;
  logic [127:0] p_in;
  logic [127:0] c_in;
  logic         is_cbc;
  logic         is_stream;
  logic         use_dec;
  logic [127:0] cin;
  logic         last;
  logic         finish;
  logic [127:0] res_next;
  logic [127:0] chain_next;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !busy && !kx_busy;
  assign in_fire   = in_valid && in_ready;
  assign kx_start  = cfg_fire && (cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ECB;
      direction <= 1'b0;
      key       <= '0;
      iv        <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_MODE:      mode          <= cfg_data[2:0];
        REG_DIRECTION: direction     <= cfg_data[0];
        REG_KEY_UPPER: key[127:64]   <= cfg_data;
        REG_KEY_LOWER: key[63:0]     <= cfg_data;
        REG_IV_UPPER:  iv[127:64]    <= cfg_data;
        REG_IV_LOWER:  iv[63:0]      <= cfg_data;
        default:       ;
      endcase
    end
  end

  aesme_key_expander u_kx (
    .clk    (clk),
    .rst    (rst),
    .start  (kx_start),
    .key    (key),
    .rd_idx (rd_idx),
    .rd_key (rd_key),
    .busy   (kx_busy)
  );

  // mode decode for a new block
  assign p_in      = {block_upper, block_lower};
  assign c_in      = message_start ? iv : chain;
  assign is_cbc    = (mode == MODE_CBC);
  assign is_stream = (mode == MODE_CFB) || (mode == MODE_OFB) || (mode == MODE_CTR);
  assign use_dec   = direction && !is_stream;

  always_comb begin
    if (is_cbc) begin
      cin = direction ? p_in : (p_in ^ c_in);
    end else if (is_stream) begin
      cin = c_in;
    end else begin
      cin = p_in;
    end
  end

  // round key select: initial key at load, then per round
  always_comb begin
    if (busy) begin
      rd_idx = dec_r ? (4'(NUM_ROUNDS) - step) : step;
    end else begin
      rd_idx = use_dec ? 4'(NUM_ROUNDS) : 4'd0;
    end
  end

  assign last     = (step == 4'(NUM_ROUNDS));
  assign ctl.dec  = dec_r;
  assign ctl.last = last;

  aesme_round_unit u_round (
    .state  (state),
    .rkey   (rd_key),
    .ctl    (ctl),
    .result (round_out)
  );

  // output and chaining update from the cipher result
  always_comb begin
    res_next   = round_out;
    chain_next = c_r;
    case (mode_r)
      MODE_CBC: begin
        if (dirn_r) begin
          res_next   = round_out ^ c_r;
          chain_next = p_r;
        end else begin
          chain_next = round_out;
        end
      end
      MODE_CFB: begin
        res_next   = p_r ^ round_out;
        chain_next = dirn_r ? p_r : (p_r ^ round_out);
      end
      MODE_OFB: begin
        res_next   = p_r ^ round_out;
        chain_next = round_out;
      end
      MODE_CTR: begin
        res_next   = p_r ^ round_out;
        chain_next = c_r + 128'd1;
      end
      default: ;
    endcase
  end

  assign finish = busy && last && (!out_valid || out_ready);

  // round sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else if (in_fire) begin
      busy <= 1'b1;
      step <= 4'd1;
    end else if (finish) begin
      busy <= 1'b0;
    end else if (busy && !last) begin
      step <= step + 4'd1;
    end
  end

  // working state of the block in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= mode;
      dirn_r <= direction;
      dec_r  <= use_dec;
      p_r    <= p_in;
      c_r    <= c_in;
      state  <= cin ^ rd_key;
    end else if (busy && !last) begin
      state <= round_out;
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (finish) begin
      chain <= chain_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_upper <= res_next[127:64];
      result_lower <= res_next[63:0];
    end
  end

  // checks
  `AESME_ASSERT_NEXT(a_accept_starts, in_fire, busy && step == 4'd1, "block accepted without starting rounds")
  `AESME_ASSERT_IMP(a_step_range, busy, step != 4'd0 && step <= 4'(NUM_ROUNDS), "round step out of range")
  `AESME_ASSERT_IMP(a_result_from_core, $rose(out_valid), $past(busy) && $past(last), "result without a finished block")

endmodule

// ===== rtl/aesme_key_expander.sv =====
// round key expansion, one round key per cycle, and the round key store
module aesme_key_expander (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [3:0]   rd_idx,
  output logic [127:0] rd_key,
  output logic         busy
);
  import aesme_pkg::*;

  logic [3:0]   cnt;
  logic [127:0] prev;
  logic [127:0] nxt;
  logic [127:0] rk [NUM_ROUNDS+1];

  assign nxt = (cnt == 4'd0) ? key : key_step(prev, cnt);

  // sequencer: reset and key writes restart the expansion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'(NUM_ROUNDS)) begin
        busy <= 1'b0;
      end
    end
  end

  // key store write
  always_ff @(posedge clk) begin
    if (busy && !start) begin
      rk[cnt] <= nxt;
      prev    <= nxt;
    end
  end

  assign rd_key = rk[rd_idx];

endmodule

// ===== rtl/aesme_round_unit.sv =====
// one aes round, forward or inverse, shared by all rounds
module aesme_round_unit (
  input  logic                  [127:0] state,
  input  logic                  [127:0] rkey,
  input  aesme_pkg::round_ctl_t         ctl,
  output logic                  [127:0] result
);
  import aesme_pkg::*;

  logic [127:0] enc_sr;
  logic [127:0] enc_mix;
  logic [127:0] dec_ark;

  // forward: sub bytes, shift rows, mix columns except last, add key
  assign enc_sr  = shift_rows(sub_bytes(state, 1'b0));
  assign enc_mix = ctl.last ? enc_sr : mix_columns(enc_sr);

  // inverse: shift rows, sub bytes, add key, mix columns except last
  assign dec_ark = sub_bytes(inv_shift_rows(state), 1'b1) ^ rkey;

  always_comb begin
    if (ctl.dec) begin
      result = ctl.last ? dec_ark : inv_mix_columns(dec_ark);
    end else begin
      result = enc_mix ^ rkey;
    end
  end

endmodule
